[src/bbd_pkg.sv]
// Shared types and constants of the burst bit decoder with change tracking.
// Used by the front end, the queue, the back end and the top level.
package bbd_pkg;

	localparam int PACKET_BITS = 4096;
	localparam int POS_W = $clog2(PACKET_BITS);
	localparam int FADE_WIDTH = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] CODE_INVALID = 2'd2;
	localparam logic [1:0] CODE_UNSEEN = 2'd3;
	localparam logic [2:0] RUN_LIMIT = 3'd5;

	localparam logic [1:0] LINE_OFF = 2'd0;
	localparam logic [1:0] LINE_M10_ONE = 2'd1;
	localparam logic [1:0] LINE_M10_ZERO = 2'd2;
	localparam logic [1:0] DIFF_NRZI = 2'd1;
	localparam logic [1:0] DIFF_NRZI_UNSTUFF = 2'd2;

	localparam logic [2:0] REG_LINE_MODE = 3'd0;
	localparam logic [2:0] REG_DIFF_MODE = 3'd1;
	localparam logic [2:0] REG_INVERT = 3'd2;
	localparam logic [2:0] REG_BIT_OFFSET = 3'd3;
	localparam logic [2:0] REG_WORD_BITS = 3'd4;
	localparam logic [2:0] REG_LSB_FIRST = 3'd5;
	localparam logic [2:0] REG_PARITY = 3'd6;
	localparam logic [2:0] REG_FADE_LIMIT = 3'd7;

	typedef struct packed {
		logic [1:0]            line_mode;
		logic [1:0]            diff_mode;
		logic                  invert_enable;
		logic [11:0]           bit_offset;
		logic [3:0]            word_bits;
		logic                  lsb_first;
		logic                  parity_enable;
		logic [FADE_WIDTH-1:0] fade_limit;
	} cfg_t;

	// One accepted input item as seen by the back end.
	typedef struct packed {
		logic [1:0]      nb;
		logic [2:0][1:0] codes;
		logic            fin;
		logic            clr;
	} entry_t;

	typedef struct packed {
		logic       bit_valid;
		logic       out_bit;
		logic       out_invalid;
		logic [11:0] position;
		logic       bit_changed;
		logic       bit_recent;
		logic       word_valid;
		logic [7:0] word_value;
		logic       word_partial;
		logic       word_changed;
		logic       word_recent;
		logic       packet_end;
	} result_t;

	function automatic logic pair_mode(input logic [1:0] lm);
		return (lm == LINE_M10_ONE) || (lm == LINE_M10_ZERO);
	endfunction

endpackage

[src/burst_bit_decoder_change_tracker_top.sv]
// Each decoded bit takes a store read, then an update and write, which waits while the result
// register holds an untaken result; each queued transaction is then moved on, a skipped position
// passes without a store access, and a flush result is produced in its own state.
// The first bit of a Manchester pair queues nothing unless it is the last bit of the packet.
// Reset: asynchronous, active low; afterward a clearing pass marks every store position
// unseen, during which no input transaction is accepted. Uses bbd_pkg and all submodules.
module burst_bit_decoder_change_tracker_top import bbd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_addr,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [0] in_bit, [7:1] zero
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] out_bit, [1] out_invalid, [13:2] position, [14] bit_changed, [15] bit_recent,
	// [23:16] word_value, [24] word_partial, [25] word_changed, [26] word_recent
	output logic [31:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,  // [0] bit_valid, [1] word_valid
	output logic        m_axis_tlast
);

	cfg_t    cfg_q;
	logic    q_full, q_valid, q_pop, push, clearing;
	entry_t  push_data, q_head;
	result_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{line_mode: LINE_OFF, diff_mode: 2'd0, invert_enable: 1'b0,
				bit_offset: 12'd0, word_bits: 4'd8, lsb_first: 1'b0,
				parity_enable: 1'b0, fade_limit: FADE_WIDTH'(10)};
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_LINE_MODE:  cfg_q.line_mode <= cfg_wdata[1:0];
				REG_DIFF_MODE:  cfg_q.diff_mode <= cfg_wdata[1:0];
				REG_INVERT:     cfg_q.invert_enable <= cfg_wdata[0];
				REG_BIT_OFFSET: cfg_q.bit_offset <= cfg_wdata[11:0];
				REG_WORD_BITS:  cfg_q.word_bits <= cfg_wdata[3:0];
				REG_LSB_FIRST:  cfg_q.lsb_first <= cfg_wdata[0];
				REG_PARITY:     cfg_q.parity_enable <= cfg_wdata[0];
				REG_FADE_LIMIT: cfg_q.fade_limit <= cfg_wdata[FADE_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	bbd_front u_front (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.in_valid(s_axis_tvalid), .in_bit(s_axis_tdata[0]), .in_last(s_axis_tlast),
		.in_ready(s_axis_tready), .q_full(q_full), .hold(clearing),
		.push(push), .push_data(push_data)
	);

	bbd_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data),
		.pop(q_pop), .full(q_full), .valid(q_valid), .head(q_head)
	);

	bbd_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q),
		.q_valid(q_valid), .q_head(q_head), .q_pop(q_pop), .clearing(clearing),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
	);

	assign m_axis_tdata = {5'd0, res.word_recent, res.word_changed, res.word_partial,
		res.word_value, res.bit_recent, res.bit_changed, res.position,
		res.out_invalid, res.out_bit};
	assign m_axis_tuser = {res.word_valid, res.bit_valid};
	assign m_axis_tlast = res.packet_end;

endmodule

[src/bbd_front.sv]
// Front end: Manchester pair decode, NRZI decode with unstuffing and inversion.
// Accepted input bits yield queue entries of up to three codes. Uses bbd_pkg.
module bbd_front import bbd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   in_valid,
	input  logic   in_bit,
	input  logic   in_last,
	output logic   in_ready,
	input  logic   q_full,
	input  logic   hold,
	output logic   push,
	output entry_t push_data
);

	logic [12:0] raw_q, raw_n;
	logic        pfirst_q, pfirst_n;
	logic [1:0]  prev_q, prev_n;
	logic [2:0]  zrun_q, zrun_n;
	logic        stuff_q, stuff_n;
	logic        flag_q, flag_n;
	logic        ended_q, ended_n;
	logic        accept;
	logic [1:0]  sym;
	logic        have, closed, d, fin;
	logic [1:0]  nb;
	logic [2:0][1:0] codes;

	assign in_ready = !q_full && !hold;
	assign accept = in_valid && in_ready;

	always_comb begin
		raw_n = raw_q; pfirst_n = pfirst_q; prev_n = prev_q; zrun_n = zrun_q;
		stuff_n = stuff_q; flag_n = flag_q; ended_n = ended_q;
		sym = 2'd0; have = 1'b0; closed = 1'b0; d = 1'b0; nb = 2'd0; codes = '0;
		if (!ended_q) begin
			if (pair_mode(cfg.line_mode)) begin
				if (raw_q < {1'b0, cfg.bit_offset}) begin
					raw_n = raw_q + 13'd1;
				end else if ((raw_q[0] ^ cfg.bit_offset[0]) == 1'b0) begin
					pfirst_n = in_bit;
					raw_n = {1'b0, cfg.bit_offset} + 13'd1;
				end else begin
					if (pfirst_q && !in_bit)
						sym = (cfg.line_mode == LINE_M10_ONE) ? 2'd1 : 2'd0;
					else if (!pfirst_q && in_bit)
						sym = (cfg.line_mode == LINE_M10_ONE) ? 2'd0 : 2'd1;
					else
						sym = CODE_INVALID;
					have = 1'b1;
					raw_n = {1'b0, cfg.bit_offset};
				end
			end else begin
				sym = {1'b0, in_bit};
				have = 1'b1;
			end
			if (have) begin
				if (cfg.diff_mode == DIFF_NRZI || cfg.diff_mode == DIFF_NRZI_UNSTUFF) begin
					d = (sym != prev_q);
					prev_n = sym;
					if (stuff_q) begin
						stuff_n = 1'b0;
						if (!d) begin
							nb = 2'd2;
							if (!flag_q) begin
								flag_n = 1'b1;
							end else begin
								flag_n = 1'b0;
								codes[2] = 2'd1;
								nb = 2'd3;
								closed = 1'b1;
							end
						end
					end else begin
						if (cfg.diff_mode == DIFF_NRZI_UNSTUFF)
							zrun_n = d ? 3'd0 : zrun_q + 3'd1;
						if (zrun_n == RUN_LIMIT) begin
							zrun_n = 3'd0;
							stuff_n = 1'b1;
						end
						codes[0] = {1'b0, d};
						nb = 2'd1;
					end
				end else begin
					codes[0] = sym;
					nb = 2'd1;
				end
				if (cfg.invert_enable) begin
					for (int i = 0; i < 3; i++)
						if (codes[i] != CODE_INVALID) codes[i][0] = !codes[i][0];
				end
			end
		end
		fin = !ended_q && (in_last || closed);
		if (closed) ended_n = 1'b1;
		if (in_last) begin
			raw_n = '0; pfirst_n = 1'b0; prev_n = '0; zrun_n = '0;
			stuff_n = 1'b0; flag_n = 1'b0; ended_n = 1'b0;
		end
	end

	assign push = accept && (nb != 2'd0 || fin || in_last);
	assign push_data = '{nb: nb, codes: codes, fin: fin, clr: in_last};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_q <= '0; pfirst_q <= 1'b0; prev_q <= '0; zrun_q <= '0;
			stuff_q <= 1'b0; flag_q <= 1'b0; ended_q <= 1'b0;
		end else if (accept) begin
			raw_q <= raw_n; pfirst_q <= pfirst_n; prev_q <= prev_n; zrun_q <= zrun_n;
			stuff_q <= stuff_n; flag_q <= flag_n; ended_q <= ended_n;
		end
	end

endmodule

[src/bbd_queue.sv]
// Short queue of decoded entries between the front and the back end.
// Depth from bbd_pkg.
module bbd_queue import bbd_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	input  logic   pop,
	output logic   full,
	output logic   valid,
	output entry_t head
);

	entry_t            slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QPTR_W:0]   cnt_q;

	assign full = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign valid = (cnt_q != '0);
	assign head = slots_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) slots_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0; rd_q <= '0; cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
		end
	end

endmodule

[src/bbd_back.sv]
// Back end: per-position store read-modify-write, word packing and result register.
// Takes entries from bbd_queue; uses bbd_pkg.
module bbd_back import bbd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  cfg_t    cfg,
	input  logic    q_valid,
	input  entry_t  q_head,
	output logic    q_pop,
	output logic    clearing,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_NEXT  = 5'b00100,
		S_RD    = 5'b01000,
		S_FLUSH = 5'b10000
	} state_t;

	localparam int MEM_W = 2 + FADE_WIDTH;

	state_t          state_q, state_n;
	entry_t          ent_q, ent_n;
	logic [1:0]      idx_q, idx_n;
	logic            any_q, any_n;
	logic [POS_W:0]  oidx_q, oidx_n;
	logic [7:0]      acc_q, acc_n;
	logic [3:0]      wcnt_q, wcnt_n;
	logic [1:0]      marks_q, marks_n;
	logic [POS_W-1:0] clr_cnt_q;
	logic            ovalid_q;
	result_t         odata_q, res;
	logic            emit, out_free;
	logic            re, we;
	logic [POS_W-1:0] waddr;
	logic [MEM_W-1:0] wdata, rdata_q;
	logic [MEM_W-1:0] mem [PACKET_BITS];

	logic [1:0]  code, v;
	logic [3:0]  wb, span, k, shift;
	logic [FADE_WIDTH-1:0] s;
	logic        changed, recent, last_res, fin_here;

	assign out_free = !ovalid_q || out_ready;
	assign clearing = (state_q == S_CLEAR);

	always_comb begin
		state_n = state_q; ent_n = ent_q; idx_n = idx_q; any_n = any_q;
		oidx_n = oidx_q; acc_n = acc_q; wcnt_n = wcnt_q; marks_n = marks_q;
		q_pop = 1'b0; emit = 1'b0; res = '0; re = 1'b0; we = 1'b0;
		waddr = clr_cnt_q; wdata = {CODE_UNSEEN, {FADE_WIDTH{1'b0}}};
		code = 2'd0; v = rdata_q[MEM_W-1 -: 2]; s = rdata_q[FADE_WIDTH-1:0];
		changed = 1'b0; recent = 1'b0; last_res = 1'b0; fin_here = 1'b0;
		wb = (cfg.word_bits == 4'd0) ? 4'd1 : ((cfg.word_bits > 4'd8) ? 4'd8 : cfg.word_bits);
		span = wb + {3'd0, cfg.parity_enable};
		k = (wcnt_q >= span) ? 4'd0 : wcnt_q;
		shift = cfg.lsb_first ? k : span - 4'd1 - k;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
				if (clr_cnt_q == POS_W'(PACKET_BITS - 1)) state_n = S_IDLE;
			end
			S_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1; ent_n = q_head; idx_n = 2'd0; any_n = 1'b0;
					state_n = S_NEXT;
				end
			end
			S_NEXT: begin
				if (idx_q < ent_q.nb) begin
					if (oidx_q[POS_W]) begin
						idx_n = idx_q + 2'd1;
					end else if (!pair_mode(cfg.line_mode)
							&& oidx_q < {1'b0, cfg.bit_offset}) begin
						oidx_n = oidx_q + 1'b1;
						idx_n = idx_q + 2'd1;
					end else begin
						re = 1'b1;
						state_n = S_RD;
					end
				end else if (ent_q.fin && !any_q) begin
					state_n = S_FLUSH;
				end else begin
					if (ent_q.clr) begin
						oidx_n = '0; acc_n = '0; wcnt_n = '0; marks_n = '0;
					end
					if (q_valid) begin
						q_pop = 1'b1; ent_n = q_head; idx_n = 2'd0; any_n = 1'b0;
					end else begin
						state_n = S_IDLE;
					end
				end
			end
			S_RD: begin
				case (idx_q)
					2'd0: code = ent_q.codes[0];
					2'd1: code = ent_q.codes[1];
					default: code = ent_q.codes[2];
				endcase
				if (out_free) begin
					emit = 1'b1;
					acc_n = (k == 4'd0) ? 8'd0 : acc_q;
					marks_n = (k == 4'd0) ? 2'd0 : marks_q;
					if (code != 2'd0 && shift < 4'd8) acc_n = acc_n | (8'd1 << shift[2:0]);
					if (v != CODE_UNSEEN && v != code) begin
						changed = 1'b1;
						s = '0;
					end else if (s < cfg.fade_limit) begin
						recent = 1'b1;
						s = s + 1'b1;
					end
					marks_n = marks_n | {recent, changed};
					we = 1'b1;
					waddr = oidx_q[POS_W-1:0];
					wdata = {code, s};
					res.bit_valid = 1'b1;
					res.out_bit = (code != 2'd0);
					res.out_invalid = (code == CODE_INVALID);
					res.position = oidx_q[11:0];
					res.bit_changed = changed;
					res.bit_recent = recent;
					if (k == span - 4'd1) begin
						res.word_valid = 1'b1;
						res.word_value = acc_n;
						res.word_changed = marks_n[0];
						res.word_recent = marks_n[1];
						wcnt_n = 4'd0;
					end else begin
						wcnt_n = k + 4'd1;
					end
					last_res = (idx_q == ent_q.nb - 2'd1)
						|| (oidx_q[POS_W-1:0] == POS_W'(PACKET_BITS - 1));
					fin_here = ent_q.fin && last_res;
					if (fin_here) begin
						if (wcnt_n != 4'd0) begin
							res.word_valid = 1'b1;
							res.word_value = acc_n;
							res.word_partial = 1'b1;
							res.word_changed = marks_n[0];
							res.word_recent = marks_n[1];
							wcnt_n = 4'd0;
						end
						res.packet_end = 1'b1;
					end
					oidx_n = oidx_q + 1'b1;
					idx_n = idx_q + 2'd1;
					any_n = 1'b1;
					state_n = S_NEXT;
				end
			end
			S_FLUSH: begin
				if (out_free) begin
					emit = 1'b1;
					if (wcnt_q != 4'd0) begin
						res.word_valid = 1'b1;
						res.word_value = acc_q;
						res.word_partial = 1'b1;
						res.word_changed = marks_q[0];
						res.word_recent = marks_q[1];
						wcnt_n = 4'd0;
					end
					res.packet_end = 1'b1;
					if (ent_q.clr) begin
						oidx_n = '0; acc_n = '0; wcnt_n = '0; marks_n = '0;
					end
					state_n = S_IDLE;
				end
			end
			default: state_n = S_IDLE;
		endcase
	end

	// Store entry: last value code in the top two bits, since-change count below.
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rdata_q <= mem[oidx_q[POS_W-1:0]];
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_n;
		if (emit) odata_q <= res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR; idx_q <= '0; any_q <= 1'b0; oidx_q <= '0;
			acc_q <= '0; wcnt_q <= '0; marks_q <= '0; clr_cnt_q <= '0;
			ovalid_q <= 1'b0;
		end else begin
			state_q <= state_n; idx_q <= idx_n; any_q <= any_n; oidx_q <= oidx_n;
			acc_q <= acc_n; wcnt_q <= wcnt_n; marks_q <= marks_n;
			if (state_q == S_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
			if (emit) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
		end
	end

	assign out_valid = ovalid_q;
	assign out_data = odata_q;

`ifndef NO_ASSERTIONS
	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> !ovalid_q)
		else $error("result presented during store clearing");
	a_write_only_when_allowed: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> (state_q == S_RD || state_q == S_CLEAR))
		else $error("store written outside update or clearing");
	a_index_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		oidx_q <= (POS_W+1)'(PACKET_BITS))
		else $error("output index beyond packet length");
	a_partial_ends_packet: assert property (@(posedge clk) disable iff (!arst_n)
		emit && res.word_partial |-> res.packet_end)
		else $error("partial word without packet end");
`endif

endmodule
